// ----- hdl/yrp_pkg.sv -----
// Shared types, constants and register map of the yaw rotation PID controller.
package yrp_pkg;

    localparam int YAW_W    = 17;
    localparam int TURNS_W  = 16;
    localparam int PWM_W    = 16;
    localparam int GAIN_W   = 16;
    localparam int WORD_W   = 32;
    localparam int TGT_W    = 24;
    localparam int DIFF_W   = 18;
    localparam int ROT_W    = 40;
    localparam int ERR_W    = 41;
    localparam int DERR_W   = 42;
    localparam int INTEG_W  = 48;
    localparam int ACC_W    = 66;
    localparam int CNT_W    = 4;
    localparam int CFG_IDX_W = 3;

    // Unwrap thresholds in 1/128 degree
    localparam logic [DIFF_W-1:0] DEG300 = DIFF_W'(38400);
    localparam logic [DIFF_W-1:0] DEG360 = DIFF_W'(46080);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN   = 3'd0,
        REG_INTEG_GAIN  = 3'd1,
        REG_DERIV_GAIN  = 3'd2,
        REG_STATIC_BND  = 3'd3,
        REG_INTEG_CAP   = 3'd4,
        REG_SPEED_FS    = 3'd5,
        REG_PWM_MIN     = 3'd6,
        REG_PWM_MAX     = 3'd7
    } cfg_index_t;

    typedef enum logic {
        REQ_START  = 1'b0,
        REQ_SAMPLE = 1'b1
    } req_type_t;

    typedef struct packed {
        logic [GAIN_W-1:0] prop_gain;
        logic [GAIN_W-1:0] integ_gain;
        logic [GAIN_W-1:0] deriv_gain;
        logic [GAIN_W-1:0] static_bound;
        logic [WORD_W-1:0] integ_cap;
        logic [WORD_W-1:0] speed_full_scale;
        logic [PWM_W-1:0]  pwm_min;
        logic [PWM_W-1:0]  pwm_max;
    } cfg_regs_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_DELTA,
        ST_ROT,
        ST_ERR,
        ST_ABS,
        ST_INTEG,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_SCALE,
        ST_MAP,
        ST_DIV,
        ST_FIN,
        ST_OUT
    } state_t;

endpackage

// ----- hdl/yrp_addsub.sv -----
// Shared wide adder/subtractor used by the multiply and divide steps.
module yrp_addsub
    import yrp_pkg::*;
(
    input  logic [ACC_W-1:0] a,
    input  logic [ACC_W-1:0] b,
    input  logic             sub,
    output logic [ACC_W-1:0] y
);

    assign y = a + (b ^ {ACC_W{sub}}) + {{(ACC_W-1){1'b0}}, sub};

endmodule

// ----- hdl/yrp_cfg.sv -----
// Configuration register file with reset values.
module yrp_cfg
    import yrp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    output cfg_regs_t            cfg_o
);

    cfg_regs_t regs_reg;
    cfg_regs_t regs_next;

    assign cfg_ready = 1'b1;
    assign cfg_o     = regs_reg;

    always_comb begin
        regs_next = regs_reg;
        if (cfg_valid) begin
            case (cfg_index_t'(cfg_index))
                REG_PROP_GAIN:  regs_next.prop_gain        = cfg_data[GAIN_W-1:0];
                REG_INTEG_GAIN: regs_next.integ_gain       = cfg_data[GAIN_W-1:0];
                REG_DERIV_GAIN: regs_next.deriv_gain       = cfg_data[GAIN_W-1:0];
                REG_STATIC_BND: regs_next.static_bound     = cfg_data[GAIN_W-1:0];
                REG_INTEG_CAP:  regs_next.integ_cap        = cfg_data;
                REG_SPEED_FS:   regs_next.speed_full_scale = cfg_data;
                REG_PWM_MIN:    regs_next.pwm_min          = cfg_data[PWM_W-1:0];
                REG_PWM_MAX:    regs_next.pwm_max          = cfg_data[PWM_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regs_reg.prop_gain        <= GAIN_W'(256);
            regs_reg.integ_gain       <= '0;
            regs_reg.deriv_gain       <= '0;
            regs_reg.static_bound     <= GAIN_W'(1280);
            regs_reg.integ_cap        <= WORD_W'(819200);
            regs_reg.speed_full_scale <= WORD_W'(65536);
            regs_reg.pwm_min          <= '0;
            regs_reg.pwm_max          <= PWM_W'(65535);
        end else begin
            regs_reg <= regs_next;
        end
    end

endmodule

// ----- hdl/yrp_core.sv -----
// Sequencer and datapath: rotation tracking, PID terms, PWM map and divide.
module yrp_core
    import yrp_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  cfg_regs_t           cfg_i,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                in_req_type,
    input  logic [YAW_W-1:0]    in_yaw,
    input  logic [TURNS_W-1:0]  in_turns,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [PWM_W-1:0]    out_pwm
);

    state_t state_reg, state_next;

    logic signed [YAW_W-1:0]   prev_yaw_reg, prev_yaw_next;
    logic signed [YAW_W-1:0]   yaw_reg, yaw_next;
    logic [YAW_W-1:0]          adiff_reg, adiff_next;
    logic signed [DIFF_W-1:0]  delta_reg, delta_next;
    logic signed [ROT_W-1:0]   rot_reg, rot_next;
    logic [TGT_W-1:0]          target_reg, target_next;
    logic signed [ERR_W-1:0]   err_reg, err_next;
    logic signed [ERR_W-1:0]   last_err_reg, last_err_next;
    logic signed [DERR_W-1:0]  derr_reg, derr_next;
    logic signed [INTEG_W-1:0] integ_reg, integ_next;
    logic                      inb_reg, inb_next;
    logic [ACC_W-1:0]          acc_reg, acc_next;
    logic [ACC_W-1:0]          mcand_reg, mcand_next;
    logic [GAIN_W-1:0]         mplier_reg, mplier_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [PWM_W-1:0]          res_reg, res_next;
    logic [PWM_W-1:0]          pwm_reg, pwm_next;
    logic                      out_valid_reg, out_valid_next;

    logic [ACC_W-1:0] alu_a, alu_b, alu_y;
    logic             alu_sub;

    logic signed [DIFF_W-1:0]  diff_s;
    logic [ERR_W-1:0]          abs_err;
    logic signed [INTEG_W:0]   isum;
    logic [PWM_W-1:0]          range_w;
    logic                      last_step;

    yrp_addsub u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .sub (alu_sub),
        .y   (alu_y)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_pwm   = pwm_reg;
    assign last_step = (cnt_reg == {CNT_W{1'b1}});
    assign range_w   = cfg_i.pwm_max - cfg_i.pwm_min;

    assign diff_s  = DIFF_W'(prev_yaw_reg) - DIFF_W'(yaw_reg);
    assign abs_err = err_reg[ERR_W-1] ? ERR_W'(-err_reg) : ERR_W'(err_reg);
    assign isum    = (INTEG_W+1)'(integ_reg) + (INTEG_W+1)'(err_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            prev_yaw_reg  <= '0;
            rot_reg       <= '0;
            target_reg    <= '0;
            integ_reg     <= '0;
            last_err_reg  <= '0;
            cnt_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            prev_yaw_reg  <= prev_yaw_next;
            rot_reg       <= rot_next;
            target_reg    <= target_next;
            integ_reg     <= integ_next;
            last_err_reg  <= last_err_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        yaw_reg    <= yaw_next;
        adiff_reg  <= adiff_next;
        delta_reg  <= delta_next;
        err_reg    <= err_next;
        derr_reg   <= derr_next;
        inb_reg    <= inb_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        res_reg    <= res_next;
        pwm_reg    <= pwm_next;
    end

    always_comb begin
        state_next     = state_reg;
        prev_yaw_next  = prev_yaw_reg;
        yaw_next       = yaw_reg;
        adiff_next     = adiff_reg;
        delta_next     = delta_reg;
        rot_next       = rot_reg;
        target_next    = target_reg;
        err_next       = err_reg;
        last_err_next  = last_err_reg;
        derr_next      = derr_reg;
        integ_next     = integ_reg;
        inb_next       = inb_reg;
        acc_next       = acc_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        cnt_next       = cnt_reg;
        res_next       = res_reg;
        pwm_next       = pwm_reg;
        out_valid_next = out_valid_reg && !out_ready;

        // default: multiply step, acc plus shifted multiplicand
        alu_a   = acc_reg;
        alu_b   = mcand_reg;
        alu_sub = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    if (req_type_t'(in_req_type) == REQ_START) begin
                        // turns * 180 = turns * (128 + 32 + 16 + 4)
                        target_next   = (TGT_W'(in_turns) << 7) + (TGT_W'(in_turns) << 5)
                                      + (TGT_W'(in_turns) << 4) + (TGT_W'(in_turns) << 2);
                        prev_yaw_next = in_yaw;
                        rot_next      = '0;
                    end else begin
                        yaw_next   = in_yaw;
                        state_next = ST_DIFF;
                    end
                end
            end
            ST_DIFF: begin
                adiff_next = diff_s[DIFF_W-1] ? YAW_W'(-diff_s) : YAW_W'(diff_s);
                state_next = ST_DELTA;
            end
            ST_DELTA: begin
                // unwrap the jump across +-180 degrees
                if (DIFF_W'(adiff_reg) >= DEG300) begin
                    delta_next = DEG360 - DIFF_W'(adiff_reg);
                end else begin
                    delta_next = DIFF_W'(adiff_reg);
                end
                state_next = ST_ROT;
            end
            ST_ROT: begin
                rot_next      = rot_reg + ROT_W'(delta_reg);
                prev_yaw_next = yaw_reg;
                state_next    = ST_ERR;
            end
            ST_ERR: begin
                err_next   = $signed({{(ERR_W-TGT_W){1'b0}}, target_reg}) - ERR_W'(rot_reg);
                state_next = ST_ABS;
            end
            ST_ABS: begin
                inb_next   = abs_err < ERR_W'(cfg_i.static_bound);
                derr_next  = DERR_W'(err_reg) - DERR_W'(last_err_reg);
                state_next = ST_INTEG;
            end
            ST_INTEG: begin
                if (!inb_reg) begin
                    integ_next = '0;
                end else if (isum > $signed({{(INTEG_W+1-WORD_W){1'b0}}, cfg_i.integ_cap})) begin
                    integ_next = INTEG_W'(cfg_i.integ_cap);
                end else if (isum[INTEG_W] && !isum[INTEG_W-1]) begin
                    // saturate at the most negative integral
                    integ_next = {1'b1, {(INTEG_W-1){1'b0}}};
                end else begin
                    integ_next = isum[INTEG_W-1:0];
                end
                last_err_next = err_reg;
                acc_next      = '0;
                mcand_next    = ACC_W'(err_reg);
                mplier_next   = cfg_i.prop_gain;
                cnt_next      = '0;
                state_next    = ST_MUL_P;
            end
            ST_MUL_P, ST_MUL_I, ST_MUL_D, ST_MAP: begin
                if (mplier_reg[0]) begin
                    acc_next = alu_y;
                end
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg + CNT_W'(1);
                if (last_step) begin
                    case (state_reg)
                        ST_MUL_P: begin
                            mcand_next  = ACC_W'(integ_reg);
                            mplier_next = cfg_i.integ_gain;
                            state_next  = ST_MUL_I;
                        end
                        ST_MUL_I: begin
                            mcand_next  = ACC_W'(derr_reg);
                            mplier_next = cfg_i.deriv_gain;
                            state_next  = ST_MUL_D;
                        end
                        ST_MUL_D: state_next = ST_SCALE;
                        default:  state_next = ST_DIV;
                    endcase
                end
            end
            ST_SCALE: begin
                if (acc_reg[ACC_W-1] || !(|acc_reg[ACC_W-2:8])
                        || (cfg_i.pwm_max <= cfg_i.pwm_min)) begin
                    res_next   = '0;
                    state_next = ST_OUT;
                end else if ((|acc_reg[ACC_W-2:WORD_W+8])
                        || (acc_reg[WORD_W+7:8] >= cfg_i.speed_full_scale)) begin
                    res_next   = cfg_i.pwm_max;
                    state_next = ST_OUT;
                end else begin
                    mcand_next  = ACC_W'(acc_reg[WORD_W+7:8]);
                    mplier_next = range_w;
                    acc_next    = '0;
                    cnt_next    = '0;
                    state_next  = ST_MAP;
                end
            end
            ST_DIV: begin
                // restoring divide, one quotient bit per cycle into acc[15:0]
                alu_a   = ACC_W'(acc_reg[47:15]);
                alu_b   = ACC_W'(cfg_i.speed_full_scale);
                alu_sub = 1'b1;
                if (!alu_y[ACC_W-1]) begin
                    acc_next = {{(ACC_W-48){1'b0}}, alu_y[WORD_W-1:0], acc_reg[14:0], 1'b1};
                end else begin
                    acc_next = {{(ACC_W-48){1'b0}}, acc_reg[46:0], 1'b0};
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (last_step) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                res_next   = (acc_reg[PWM_W-1:0] == '0) ? '0
                                                        : cfg_i.pwm_min + acc_reg[PWM_W-1:0];
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready) begin
                    pwm_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    a_div_rem_below_scale: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && last_step)
            |=> acc_reg[47:16] < cfg_i.speed_full_scale)
        else $error("divide remainder not below full scale");

    a_result_from_out_state: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside output state");

    a_stalled_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && out_valid_reg && !out_ready) |=> state_reg == ST_OUT)
        else $error("pending result overwritten");

    a_counter_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg != '0) |-> (state_reg == ST_MUL_P || state_reg == ST_MUL_I
            || state_reg == ST_MUL_D || state_reg == ST_MAP || state_reg == ST_DIV))
        else $error("step counter running outside iterative states");

endmodule

// ----- hdl/yaw_rotation_pid_controller_top.sv -----
// Top level of the yaw rotation PID controller: stream ports and config port.
// Start request: taken with no result. A sample request runs on one shared 66-bit adder
// doing three 16-step shift-add products, a 16-step map product and a 16-step restoring
// divide; the map product and divide are skipped when the PWM value saturates or is zero.
// One request at a time: the next sample is taken once the last result is registered,
// later while the result register is still full.
module yaw_rotation_pid_controller_top
    import yrp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [39:0]          s_tdata,   // yaw [16:0], turns [32:17], zero pad
    input  logic                 s_tuser,   // req_type
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,   // pwm_out
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data
);

    // Synchronous reset (aresetn low) clears the tracking state and loads default registers.
    cfg_regs_t cfg;

    yrp_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_o     (cfg)
    );

    yrp_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_i       (cfg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_req_type (s_tuser),
        .in_yaw      (s_tdata[YAW_W-1:0]),
        .in_turns    (s_tdata[YAW_W+TURNS_W-1:YAW_W]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_pwm     (m_tdata)
    );

endmodule

// ----- tb/tb_yaw_rotation_pid_controller_top.sv -----
// Self-checking testbench for the yaw rotation PID controller against a PWM predictor.
module tb_yaw_rotation_pid_controller_top
    import yrp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     CYCLE_LIMIT  = 1_000_000;
    localparam int     TAIL_CYCLES  = 120;
    localparam int     HOLD_CYCLES  = 600;
    localparam int     PHASE_ITEMS  = 180;
    localparam int     NUM_PHASES   = 10;
    localparam int     IDLE_PCT     = 28;
    localparam int     HALF_TURN    = 23040;
    localparam longint WRAP_LIMIT   = 38400;
    localparam longint FULL_TURN    = 46080;
    localparam longint TURN_UNITS   = 180;
    localparam longint INTEG_FLOOR  = -(64'sd1 <<< 47);
    localparam longint I64_MIN      = 64'h8000_0000_0000_0000;
    localparam longint I64_MAX      = 64'h7FFF_FFFF_FFFF_FFFF;

    // Tracks rotation, integral and derivative state and predicts each drive value.
    class pwm_tracker;
        longint kp = 256, ki = 0, kd = 0, bound = 1280;
        longint cap = 819200, full_scale = 65536, pwm_min = 0, pwm_max = 65535;
        longint prev_yaw = 0, rot_sum = 0, rot_target = 0, err_integ = 0, last_err = 0;
        logic [15:0] pwm_due[$];
        int errors = 0, n_start = 0, n_sample = 0, n_checked = 0, n_zero = 0;

        function void set_reg(cfg_index_t idx, logic [31:0] data);
            case (idx)
                REG_PROP_GAIN:  kp = longint'(data[15:0]);
                REG_INTEG_GAIN: ki = longint'(data[15:0]);
                REG_DERIV_GAIN: kd = longint'(data[15:0]);
                REG_STATIC_BND: bound = longint'(data[15:0]);
                REG_INTEG_CAP:  cap = longint'(data);
                REG_SPEED_FS:   full_scale = longint'(data);
                REG_PWM_MIN:    pwm_min = longint'(data[15:0]);
                REG_PWM_MAX:    pwm_max = longint'(data[15:0]);
                default: ;
            endcase
        endfunction

        function longint sat_sum(longint a, longint b);
            if (b < 0 && a < I64_MIN - b) return I64_MIN;
            if (b > 0 && a > I64_MAX - b) return I64_MAX;
            return a + b;
        endfunction

        function void take_request(req_type_t kind, logic [16:0] yaw_bits, logic [15:0] turns);
            longint yaw, delta, err, aerr, p, i, d, total;
            longint unsigned s, span, pwm;
            logic [39:0] rot_bits;
            yaw = longint'($signed(yaw_bits));
            if (kind == REQ_START) begin
                prev_yaw = yaw;
                rot_target = longint'(turns) * TURN_UNITS;
                rot_sum = 0;
                n_start++;
                return;
            end
            n_sample++;
            delta = prev_yaw - yaw;
            if (delta < 0) delta = -delta;
            // unwrap a jump across +-180 degrees
            if (delta >= WRAP_LIMIT) delta = FULL_TURN - delta;
            rot_bits = 40'(rot_sum + delta);
            rot_sum = longint'($signed(rot_bits));
            prev_yaw = yaw;

            err = rot_target - rot_sum;
            aerr = (err < 0) ? -err : err;
            if (aerr < bound) begin
                err_integ = err_integ + err;
                if (err_integ > cap) err_integ = cap;
                if (err_integ < INTEG_FLOOR) err_integ = INTEG_FLOOR;
            end else begin
                err_integ = 0;
            end

            p = err * kp;
            i = err_integ * ki;
            d = (err - last_err) * kd;
            last_err = err;
            total = sat_sum(p + d, i);

            pwm = 0;
            if (total >= 256 && pwm_max > pwm_min) begin
                s = total >>> 8;
                span = pwm_max - pwm_min;
                if (s >= full_scale) pwm = pwm_max;
                else pwm = pwm_min + (s * span) / full_scale;
                if (pwm < pwm_min + 1) pwm = 0;
            end
            pwm_due.push_back(pwm[15:0]);
        endfunction

        function void check_pwm(logic [15:0] got);
            logic [15:0] want;
            if (pwm_due.size() == 0) begin
                $display("%0t: pwm_out %0d arrived with no request outstanding", $time, got);
                errors++;
                return;
            end
            want = pwm_due.pop_front();
            n_checked++;
            if (want == 16'd0) n_zero++;
            if (got !== want) begin
                $display("%0t: pwm_out expected %0d, got %0d", $time, want, got);
                errors++;
            end
        endfunction

        function int pending();
            return pwm_due.size();
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [39:0]          s_tdata;   // yaw [16:0], turns [32:17], zero pad
    logic                 s_tuser;   // req_type
    logic                 m_tvalid;
    logic                 m_tready;
    logic [15:0]          m_tdata;   // pwm_out
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WORD_W-1:0]    cfg_data;

    pwm_tracker tracker = new();
    logic src_quiet = 1'b0;
    logic sink_quiet = 1'b0;
    logic hold_toggle = 1'b0;
    int   cycle_count = 0;
    int   items_sent = 0;
    int   settings_used = 0;

    yaw_rotation_pid_controller_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) tracker.check_pwm(m_tdata);
    end

    // Result side: random stalls, plus a long hold-off each time hold_toggle flips.
    initial begin : result_sink
        int   hold_left;
        logic seen_toggle;
        hold_left = 0;
        seen_toggle = 1'b0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_toggle != seen_toggle) begin
                seen_toggle = hold_toggle;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= sink_quiet || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    task automatic send_req(input req_type_t kind, input logic [16:0] yaw,
                            input logic [15:0] turns);
        if (!src_quiet && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < IDLE_PCT);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {7'd0, turns, yaw};
        do @(posedge aclk); while (!s_tready);
        tracker.take_request(kind, yaw, turns);
        items_sent++;
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        tracker.set_reg(idx, data);
    endtask

    // Hold until every drive value has come back, then let the block go quiet.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    task automatic apply_settings(input int phase);
        logic [31:0] regval [8];
        regval[REG_PROP_GAIN]  = 32'd256;
        regval[REG_INTEG_GAIN] = 32'd0;
        regval[REG_DERIV_GAIN] = 32'd0;
        regval[REG_STATIC_BND] = 32'd1280;
        regval[REG_INTEG_CAP]  = 32'd819200;
        regval[REG_SPEED_FS]   = 32'd65536;
        regval[REG_PWM_MIN]    = 32'd0;
        regval[REG_PWM_MAX]    = 32'd65535;
        case (phase)
            0: ;
            1: begin
                regval[REG_PROP_GAIN]  = 32'hFFFF;
                regval[REG_INTEG_GAIN] = 32'hFFFF;
                regval[REG_DERIV_GAIN] = 32'hFFFF;
                regval[REG_STATIC_BND] = 32'hFFFF;
                regval[REG_INTEG_CAP]  = 32'hFFFF_FFFF;
                regval[REG_SPEED_FS]   = 32'hFFFF_FFFF;
            end
            2: begin
                regval[REG_PROP_GAIN]  = 32'd0;
                regval[REG_STATIC_BND] = 32'd0;
                regval[REG_INTEG_CAP]  = 32'd0;
                regval[REG_SPEED_FS]   = 32'd0;
                regval[REG_PWM_MAX]    = 32'd0;
            end
            3: begin
                // zero full scale: any sum from 256 up drives the top of range
                regval[REG_INTEG_GAIN] = 32'd16;
                regval[REG_SPEED_FS]   = 32'd0;
                regval[REG_PWM_MIN]    = 32'd1000;
                regval[REG_PWM_MAX]    = 32'd50000;
            end
            4: begin
                regval[REG_PWM_MIN] = 32'hFFFF;
                regval[REG_PWM_MAX] = 32'd0;
            end
            default: begin
                regval[REG_PROP_GAIN]  = $urandom_range(0, 2048);
                regval[REG_INTEG_GAIN] = $urandom_range(0, 64);
                regval[REG_DERIV_GAIN] = $urandom_range(0, 1024);
                regval[REG_STATIC_BND] = $urandom_range(0, 8000);
                regval[REG_INTEG_CAP]  = $urandom_range(0, 2_000_000);
                regval[REG_SPEED_FS]   = $urandom_range(1, 200_000);
                regval[REG_PWM_MIN]    = $urandom_range(0, 20000);
                regval[REG_PWM_MAX]    = $urandom_range(0, 65535);
            end
        endcase
        for (int i = 0; i < 8; i++) write_reg(cfg_index_t'(i), regval[i]);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Start a rotation, then follow the heading in small steps that wrap at +-180 degrees.
    task automatic rotation_run(input int max_len);
        int heading, dir, len;
        logic [15:0] turns;
        turns = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400));
        heading = $urandom_range(0, 2 * HALF_TURN - 1) - HALF_TURN;
        dir = $urandom_range(1) ? 1 : -1;
        len = $urandom_range(1, max_len);
        send_req(REQ_START, 17'(heading), turns);
        repeat (len) begin
            if ($urandom_range(9) == 0) dir = -dir;
            heading += dir * $urandom_range(0, 1500);
            if (heading >= HALF_TURN) heading -= 2 * HALF_TURN;
            if (heading < -HALF_TURN) heading += 2 * HALF_TURN;
            send_req(REQ_SAMPLE, 17'(heading), 16'($urandom));
        end
    endtask

    task automatic run_traffic(input int count);
        int goal;
        goal = items_sent + count;
        while (items_sent < goal) begin
            if ($urandom_range(99) < 75) begin
                rotation_run(40);
            end else begin
                repeat ($urandom_range(1, 8))
                    send_req(req_type_t'($urandom_range(1)), 17'($urandom), 16'($urandom));
            end
        end
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tuser   <= REQ_START;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_PROP_GAIN;
        cfg_data  <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed requests under the reset register values
        send_req(REQ_START,  17'd0, 16'd0);
        send_req(REQ_SAMPLE, 17'd0, 16'd0);
        send_req(REQ_START,  17'h10000, 16'hFFFF);
        send_req(REQ_SAMPLE, 17'h0FFFF, 16'd0);        // out-of-range jump unwraps negative
        send_req(REQ_SAMPLE, 17'(-46080), 16'hFFFF);
        send_req(REQ_SAMPLE, 17'(46080), 16'd0);
        send_req(REQ_START,  17'(23000), 16'd1);
        send_req(REQ_SAMPLE, 17'(-23000), 16'd0);      // wrap across 180 degrees
        send_req(REQ_SAMPLE, 17'(15400), 16'd0);       // change right at 300 degrees
        send_req(REQ_START,  17'd0, 16'd200);
        send_req(REQ_SAMPLE, 17'(38399), 16'd0);       // change just below 300 degrees
        send_req(REQ_SAMPLE, 17'(38399), 16'd0);
        send_req(REQ_START,  17'(-1), 16'd300);
        send_req(REQ_SAMPLE, 17'(-20000), 16'd0);
        send_req(REQ_SAMPLE, 17'(-20512), 16'd0);
        send_req(REQ_SAMPLE, 17'(-20600), 16'd0);
        settle();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            apply_settings(phase);
            src_quiet  <= (phase == 5);
            sink_quiet <= (phase == 5);
            run_traffic(PHASE_ITEMS);
            settle();
        end
        src_quiet  <= 1'b0;
        sink_quiet <= 1'b0;

        // back-pressure: hold the result side while samples keep coming
        apply_settings(0);
        hold_toggle <= ~hold_toggle;
        send_req(REQ_START, 17'd0, 16'd120);
        repeat (30) send_req(REQ_SAMPLE, 17'($urandom_range(0, 3000)), 16'd0);
        settle();

        $display("covered %0d requests (%0d starts, %0d samples) over %0d register settings",
                 items_sent, tracker.n_start, tracker.n_sample, settings_used);
        $display("checked %0d drive values, %0d of them zero, %0d failures",
                 tracker.n_checked, tracker.n_zero, tracker.errors);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
